// ===== sv/b64d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Character codes, the alphabet decode function and the job record passed
// from the front end to the output sequencer.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
	localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
	localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
	localparam logic [7:0] CHAR_LO_A  = 8'h61;  // 'a'
	localparam logic [7:0] CHAR_DIG_0 = 8'h30;  // '0'
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// One accepted character's worth of result words (one to three).
	typedef struct packed {
		logic [1:0] n;        // number of words, 1..3
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic       valid;    // 0 for an empty end marker
		logic       last;     // character closed the message
		logic       halted;
	} b64d_job_t;

	// Returns {hit, value}; hit is low outside the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = 7'd0;
		case (c) inside
			[8'h41:8'h5A]: begin
				d = c - CHAR_UP_A;
				r = {1'b1, d[5:0]};
			end
			[8'h61:8'h7A]: begin
				d = c - CHAR_LO_A + 8'd26;
				r = {1'b1, d[5:0]};
			end
			[8'h30:8'h39]: begin
				d = c - CHAR_DIG_0 + 8'd52;
				r = {1'b1, d[5:0]};
			end
			CHAR_PLUS:  r = {1'b1, 6'd62};
			CHAR_SLASH: r = {1'b1, 6'd63};
			default:    r = 7'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/base64_stream_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: streaming base64 decoder
// Characters enter on a queue-style port (push/full) and decoded bytes leave
// on another (empty/pop); cfg_we/cfg_wdata set the skip-to-comma register.
//
// One character is taken every cycle while full is low. Each character
// produces zero to three result words: three bytes when a group of four
// completes, one or two bytes flushed by padding or the end of a message,
// and an empty end marker when the closing character brings no byte.
// A character's result words pass through the job queue and the output
// register. The output side delivers one word per cycle while pop is high,
// set by the single output register; a job queue of Q_DEPTH entries
// absorbs bursts, and full rises only when that queue is full, e.g. while
// pop is held low. Reset clears the message state, the queue, the output
// valid flag and the skip-to-comma register; no clearing pass is needed.
// A receiver stall holds the current word until popped and back-pressures
// intake through the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit import b64d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_in,
	input  wire logic       last_char,
	input  wire logic       pop,
	output logic            empty,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            message_end,
	output logic            stopped_early
);

	b64d_job_t job;
	b64d_job_t head;
	logic      job_vld;
	logic      q_full;
	logic      q_empty;
	logic      head_pop;
	logic      accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.char_in   (char_in),
		.last_char (last_char),
		.job       (job),
		.job_vld   (job_vld)
	);

	b64d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_vld),
		.wr_job  (job),
		.q_full  (q_full),
		.rd      (head_pop),
		.rd_job  (head),
		.q_empty (q_empty)
	);

	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_empty    (q_empty),
		.head_pop      (head_pop),
		.pop           (pop),
		.empty         (empty),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.message_end   (message_end),
		.stopped_early (stopped_early)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_vld |-> !q_full)
		else $error("job written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> !q_empty)
		else $error("job taken from an empty queue");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && message_end) |-> run_last)
		else $error("message end word not closing its run");

	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (message_end && run_last))
		else $error("empty marker outside a message end");

endmodule
`default_nettype wire

// ===== sv/b64d_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front: character intake and classification
// Decodes one accepted character per cycle, tracks header, halt and held
// sextets, and builds the job of result bytes that the character completes.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       accept,
	input  wire logic [7:0] char_in,
	input  wire logic       last_char,
	output b64d_job_t       job,
	output logic            job_vld
);

	logic        skip_q;
	logic [17:0] store_q;
	logic [1:0]  cnt_q;
	logic        halt_q;
	logic        hdr_q;

	logic [17:0] st_n;
	logic [1:0]  cnt_n;
	logic        halt_n;
	logic        hdr_n;
	logic        flush_pad;
	logic        full_emit;
	logic        do_flush;
	logic [6:0]  dec;
	logic [23:0] quad;

	assign dec  = sextet_of(char_in);
	assign quad = {store_q, dec[5:0]};

	always_comb begin
		st_n      = store_q;
		cnt_n     = cnt_q;
		halt_n    = halt_q;
		hdr_n     = hdr_q;
		flush_pad = 1'b0;
		full_emit = 1'b0;
		if (!halt_q) begin
			if (skip_q && !hdr_q) begin
				if (char_in == CHAR_COMMA) hdr_n = 1'b1;
			end else if (char_in == CHAR_PAD) begin
				halt_n    = 1'b1;
				flush_pad = 1'b1;
			end else if (!dec[6]) begin
				// invalid character: stop and drop what is held
				halt_n = 1'b1;
				st_n   = 18'd0;
				cnt_n  = 2'd0;
			end else if (cnt_q == 2'd3) begin
				full_emit = 1'b1;
				st_n      = 18'd0;
				cnt_n     = 2'd0;
			end else begin
				st_n  = {store_q[11:0], dec[5:0]};
				cnt_n = cnt_q + 2'd1;
			end
		end
		do_flush = flush_pad || (last_char && !halt_n);
	end

	always_comb begin
		job        = '0;
		job.valid  = 1'b1;
		job.last   = last_char;
		job.halted = halt_n;
		if (full_emit) begin
			job.n     = 2'd3;
			job.byte0 = quad[23:16];
			job.byte1 = quad[15:8];
			job.byte2 = quad[7:0];
		end else if (do_flush) begin
			case (cnt_n)
				2'd2: begin
					job.n     = 2'd1;
					job.byte0 = st_n[11:4];
				end
				2'd3: begin
					job.n     = 2'd2;
					job.byte0 = st_n[17:10];
					job.byte1 = st_n[9:2];
				end
				default: job.n = 2'd0;
			endcase
		end
		// no bytes on the closing character: send an empty end marker
		if (last_char && job.n == 2'd0) begin
			job.n     = 2'd1;
			job.valid = 1'b0;
		end
	end

	assign job_vld = accept && (job.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (cfg_we) begin
			skip_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= 18'd0;
			cnt_q   <= 2'd0;
			halt_q  <= 1'b0;
			hdr_q   <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				store_q <= 18'd0;
				cnt_q   <= 2'd0;
				halt_q  <= 1'b0;
				hdr_q   <= 1'b0;
			end else begin
				store_q <= do_flush ? 18'd0 : st_n;
				cnt_q   <= do_flush ? 2'd0 : cnt_n;
				halt_q  <= halt_n;
				hdr_q   <= hdr_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/b64d_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue: job queue between front end and output sequencer
// Small circular buffer of jobs; lets intake and output stall independently.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr,
	input  wire b64d_job_t  wr_job,
	output logic            q_full,
	input  wire logic       rd,
	output b64d_job_t       rd_job,
	output logic            q_empty
);

	b64d_job_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]    wptr_q;
	logic [Q_AW-1:0]    rptr_q;
	logic [Q_AW:0]      cnt_q;

	assign q_full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_job  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/b64d_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back: output sequencer
// Splits the head job into result words and holds one word in the output
// register until it is popped.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire b64d_job_t  head,
	input  wire logic       head_empty,
	output logic            head_pop,
	input  wire logic       pop,
	output logic            empty,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            message_end,
	output logic            stopped_early
);

	logic       out_v_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;
	logic       end_of_job;
	logic [7:0] sel_byte;

	assign take       = pop && out_v_q;
	assign load       = !head_empty && (!out_v_q || take);
	assign end_of_job = (idx_q == head.n - 2'd1);
	assign head_pop   = load && end_of_job;
	assign empty      = !out_v_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.byte0;
			2'd1:    sel_byte = head.byte1;
			2'd2:    sel_byte = head.byte2;
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= end_of_job ? 2'd0 : idx_q + 2'd1;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload: hold until the next word loads
	always_ff @(posedge clk) begin
		if (load) begin
			data_byte     <= sel_byte;
			byte_valid    <= head.valid;
			run_last      <= end_of_job;
			message_end   <= end_of_job && head.last;
			stopped_early <= head.halted;
		end
	end

endmodule
`default_nettype wire

// ===== dv/base64_decode_checker.sv =====
// ----------------------------------------------------------------------------
// base64_decode_checker: prediction and comparison for the base64 decoder
// Watches the character and byte queues of the decoder, predicts the words
// that each accepted character causes and compares every popped word with
// the oldest predicted one. Reports the failure count and the number of
// words still due.
// ----------------------------------------------------------------------------
module base64_decode_checker import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] char_in,
	input  logic       last_char,
	input  logic       pop,
	input  logic       empty,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       run_last,
	input  logic       message_end,
	input  logic       stopped_early,
	output int         fail_count,
	output int         words_due
);

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_end;
		logic       msg_end;
		logic       stopped;
	} dec_word_t;

	dec_word_t  due_words[$];

	logic       skip_hdr;
	logic [17:0] held;
	logic [1:0] held_cnt;
	logic       halted;
	logic       hdr_done;
	logic [7:0] out_bytes [3];
	int         out_n;

	// {hit, value}; hit low for a character outside the alphabet
	function automatic logic [6:0] alpha_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "A" && c <= "Z")
			v = c - "A";
		else if (c >= "a" && c <= "z")
			v = c - "a" + 8'd26;
		else if (c >= "0" && c <= "9")
			v = c - "0" + 8'd52;
		else if (c == "+")
			v = 8'd62;
		else if (c == "/")
			v = 8'd63;
		else
			return 7'd0;
		return {1'b1, v[5:0]};
	endfunction

	// emit the whole bytes that the held values complete
	task automatic flush_held();
		case (held_cnt)
			2'd2: begin
				out_bytes[out_n] = held[11:4];
				out_n++;
			end
			2'd3: begin
				out_bytes[out_n]     = held[17:10];
				out_bytes[out_n + 1] = held[9:2];
				out_n += 2;
			end
			default: ;
		endcase
		held     = '0;
		held_cnt = '0;
	endtask

	task automatic decode_char(input logic [7:0] c, input logic fin);
		logic [6:0]  hit_val;
		logic [23:0] grp;
		dec_word_t   w;
		out_n   = 0;
		hit_val = alpha_value(c);
		if (!halted) begin
			if (skip_hdr && !hdr_done) begin
				if (c == CHAR_COMMA)
					hdr_done = 1'b1;
			end else if (c == CHAR_PAD) begin
				halted = 1'b1;
				flush_held();
			end else if (!hit_val[6]) begin
				// invalid character: stop and drop what is held
				halted   = 1'b1;
				held     = '0;
				held_cnt = '0;
			end else if (held_cnt == 2'd3) begin
				grp          = {held, hit_val[5:0]};
				out_bytes[0] = grp[23:16];
				out_bytes[1] = grp[15:8];
				out_bytes[2] = grp[7:0];
				out_n        = 3;
				held         = '0;
				held_cnt     = '0;
			end else begin
				held     = {held[11:0], hit_val[5:0]};
				held_cnt = held_cnt + 2'd1;
			end
		end
		if (fin && !halted)
			flush_held();
		for (int k = 0; k < out_n; k++) begin
			w.data    = out_bytes[k];
			w.valid   = 1'b1;
			w.run_end = (k == out_n - 1);
			w.msg_end = (k == out_n - 1) && fin;
			w.stopped = halted;
			due_words.push_back(w);
		end
		if (fin && out_n == 0) begin
			w = '{data: 8'd0, valid: 1'b0, run_end: 1'b1, msg_end: 1'b1, stopped: halted};
			due_words.push_back(w);
		end
		if (fin) begin
			held     = '0;
			held_cnt = '0;
			halted   = 1'b0;
			hdr_done = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dec_word_t got;
		dec_word_t want;
		if (!arst_n) begin
			skip_hdr = 1'b0;
			held     = '0;
			held_cnt = '0;
			halted   = 1'b0;
			hdr_done = 1'b0;
			due_words.delete();
		end else begin
			if (cfg_we)
				skip_hdr = cfg_wdata;
			if (push && !full)
				decode_char(char_in, last_char);
			if (pop && !empty) begin
				got = {data_byte, byte_valid, run_last, message_end, stopped_early};
				if (due_words.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected word: byte %02h valid %b run_last %b end %b stopped %b",
							$time, got.data, got.valid, got.run_end, got.msg_end, got.stopped);
					fail_count++;
				end else begin
					want = due_words.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("%0t: mismatch: expected byte %02h valid %b run_last %b end %b stopped %b, got byte %02h valid %b run_last %b end %b stopped %b",
								$time, want.data, want.valid, want.run_end, want.msg_end,
								want.stopped, got.data, got.valid, got.run_end, got.msg_end,
								got.stopped);
						fail_count++;
					end
				end
			end
		end
		words_due = due_words.size();
	end

endmodule

// ===== dv/tb_base64_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_unit: testbench of the base64 stream decoder
// Sends directed and random messages (well-formed groups, padding, invalid
// characters, headers with and without comma) under both settings of the
// skip-to-comma register, with random gaps on the character side and random
// stalls on the byte side. A checker beside the decoder does the comparison.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_unit;
	import b64d_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 160;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       push;
	logic       full;
	logic [7:0] char_in;
	logic       last_char;
	logic       pop;
	logic       empty;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       run_last;
	logic       message_end;
	logic       stopped_early;

	int         fail_count;
	int         words_due;
	int         rand_sent;
	logic [7:0] msg[$];

	base64_stream_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.char_in      (char_in),
		.last_char    (last_char),
		.pop          (pop),
		.empty        (empty),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.message_end  (message_end),
		.stopped_early(stopped_early)
	);

	base64_decode_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.char_in      (char_in),
		.last_char    (last_char),
		.pop          (pop),
		.empty        (empty),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.message_end  (message_end),
		.stopped_early(stopped_early),
		.fail_count   (fail_count),
		.words_due    (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [7:0] alpha_char(input int v);
		if (v < 26)
			return 8'("A" + v);
		if (v < 52)
			return 8'("a" + v - 26);
		if (v < 62)
			return 8'("0" + v - 52);
		return (v == 62) ? 8'("+") : 8'("/");
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin, input bit calm);
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push      <= 1'b1;
		char_in   <= c;
		last_char <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_message(input bit calm);
		for (int i = 0; i < msg.size(); i++)
			send_char(msg[i], i == msg.size() - 1, calm);
		msg.delete();
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endtask

	// hold until every word is out, then leave room for the decoder to settle
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_skip(input logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic build_random_msg(input bit hdr_on);
		int kind;
		int n;
		logic [7:0] b;
		kind = $urandom_range(0, 9);
		if (hdr_on && kind != 0) begin
			n = $urandom_range(0, 4);
			repeat (n) begin
				b = 8'($urandom_range(0, 255));
				msg.push_back(b == CHAR_COMMA ? 8'("x") : b);
			end
			msg.push_back(CHAR_COMMA);
		end
		n = $urandom_range(0, 14);
		repeat (n)
			msg.push_back(alpha_char($urandom_range(0, 63)));
		if (kind == 1 || kind == 2) begin
			msg.push_back(CHAR_PAD);
			if ($urandom_range(0, 1))
				msg.push_back(CHAR_PAD);
			repeat ($urandom_range(0, 3))
				msg.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 3) begin
			msg.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 4))
				msg.push_back(alpha_char($urandom_range(0, 63)));
		end
		if (msg.size() == 0)
			msg.push_back(alpha_char($urandom_range(0, 63)));
	endtask

	// byte side: mostly ready, short and occasional long stalls
	initial begin
		int hold;
		int r;
		hold = 0;
		pop  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 8)
					hold = $urandom_range(1, 3);
				else if (r < 10)
					hold = $urandom_range(15, 40);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		bit calm;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		push      = 1'b0;
		char_in   = 8'd0;
		last_char = 1'b0;
		rand_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		set_skip(1'b0);
		// full group, padding flush, characters ignored after padding
		load_text("/+9aZA==");
		send_message(1'b0);
		// single held value dropped at the end
		load_text("AB9+Q");
		send_message(1'b0);
		// invalid character, then extremes of the byte range
		load_text("A");
		msg.push_back(8'hFF);
		msg.push_back(8'h00);
		send_message(1'b1);

		set_skip(1'b1);
		// header holding padding and an invalid character
		load_text("h=");
		msg.push_back(8'h80);
		load_text(",QQ==");
		send_message(1'b0);
		// no comma: whole message dropped
		load_text("ab=");
		send_message(1'b0);

		for (int p = 0; p < 6; p++) begin
			set_skip(1'(p % 2));
			while (rand_sent < (p + 1) * RAND_ITEMS / 6) begin
				calm = ($urandom_range(0, 3) == 0);
				build_random_msg(1'(p % 2));
				rand_sent += msg.size();
				send_message(calm);
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
